### src/mme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int DEF_MAX_DIM   = 8;
    localparam int DEF_ELEM_BITS = 16;

    localparam int IDX_W  = 3;
    localparam int VAL_W  = 16;
    localparam int RES_W  = 36;
    localparam int CFG_W  = 4;
    localparam int CFG_IW = 2;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_A_ROWS    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_B_COLS    = 2'd2;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [IDX_W-1:0]        elem_row;
        logic [IDX_W-1:0]        elem_col;
        logic signed [VAL_W-1:0] elem_value;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0]        res_row;
        logic [IDX_W-1:0]        res_col;
        logic signed [RES_W-1:0] res_value;
        logic                    last;
    } t_out_req;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_PUSH
    } t_state;

endpackage
`default_nettype wire

### src/mme_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_ram
// Element store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mme_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### src/mme_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_mac
// Shared multiply-accumulate unit: product register, then accumulator.
// ----------------------------------------------------------------------------
module mme_mac #(
    parameter int ELEM_BITS = mme_pkg::DEF_ELEM_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mme_pkg::t_mac_ctl             i_ctl,
    input  wire logic signed [ELEM_BITS-1:0]   i_a,
    input  wire logic signed [ELEM_BITS-1:0]   i_b,
    output logic                               o_done,
    output logic signed [mme_pkg::RES_W-1:0]   o_acc
);
    import mme_pkg::*;

    localparam int PROD_W = 2 * ELEM_BITS;

    t_mac_ctl                  r_ctl1;
    t_mac_ctl                  r_ctl2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [RES_W-1:0]   w_prod_ext;
    logic signed [RES_W-1:0]   r_acc;
    logic signed [RES_W-1:0]   n_acc;
    logic                      r_done;

    generate
        if (PROD_W >= RES_W) begin : g_trunc
            assign w_prod_ext = r_prod[RES_W-1:0];
        end else begin : g_sext
            assign w_prod_ext = {{(RES_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    endgenerate

    always_comb begin
        n_acc = r_acc;
        if (r_ctl2.valid) begin
            n_acc = (r_ctl2.first ? '0 : r_acc) + w_prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_done <= r_ctl2.valid && r_ctl2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_acc  <= n_acc;
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule
`default_nettype wire

### src/mme_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_seq
// Sequencer: walks row, column and inner index, feeds the MAC unit and
// holds the result register.
// ----------------------------------------------------------------------------
module mme_seq #(
    parameter int MAX_DIM = mme_pkg::DEF_MAX_DIM,
    parameter int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    parameter int ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [DIM_W-1:0]              i_row_last,
    input  wire logic [DIM_W-1:0]              i_col_last,
    input  wire logic [DIM_W-1:0]              i_k_last,
    output logic                               o_busy,
    output logic [ADDR_W-1:0]                  o_a_addr,
    output logic [ADDR_W-1:0]                  o_b_addr,
    output mme_pkg::t_mac_ctl                  o_ctl,
    input  wire logic                          i_mac_done,
    input  wire logic signed [mme_pkg::RES_W-1:0] i_acc,
    output logic                               o_out_valid,
    output mme_pkg::t_out_req                  o_out_req,
    input  wire logic                          i_out_stall
);
    import mme_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [DIM_W-1:0] r_row;
    logic [DIM_W-1:0] n_row;
    logic [DIM_W-1:0] r_col;
    logic [DIM_W-1:0] n_col;
    logic [DIM_W-1:0] r_k;
    logic [DIM_W-1:0] n_k;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_req         r_out_req;
    t_out_req         n_out_req;
    logic             w_out_free;
    logic             w_last_elem;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_last_elem = (r_row == i_row_last) && (r_col == i_col_last);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_k == i_k_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_mac_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (w_out_free) begin
                    n_state = w_last_elem ? ST_IDLE : ST_RUN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // counters, MAC control and result register
    always_comb begin
        n_row       = r_row;
        n_col       = r_col;
        n_k         = r_k;
        n_out_req   = r_out_req;
        n_out_valid = r_out_valid && i_out_stall;
        o_ctl       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_row = '0;
                    n_col = '0;
                    n_k   = '0;
                end
            end
            ST_RUN: begin
                o_ctl.valid = 1'b1;
                o_ctl.first = (r_k == '0);
                o_ctl.last  = (r_k == i_k_last);
                n_k         = (r_k == i_k_last) ? '0 : r_k + 1'b1;
            end
            ST_WAIT: begin
                n_k = '0;
            end
            ST_PUSH: begin
                if (w_out_free) begin
                    n_out_valid         = 1'b1;
                    n_out_req.res_row   = IDX_W'(r_row);
                    n_out_req.res_col   = IDX_W'(r_col);
                    n_out_req.res_value = i_acc;
                    n_out_req.last      = w_last_elem;
                    if (r_col == i_col_last) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            default: begin
                n_k = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_row       <= n_row;
            r_col       <= n_col;
            r_k         <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_req <= n_out_req;
    end

    assign o_a_addr    = ADDR_W'(r_row) * ADDR_W'(MAX_DIM) + ADDR_W'(r_k);
    assign o_b_addr    = ADDR_W'(r_k) * ADDR_W'(MAX_DIM) + ADDR_W'(r_col);
    assign o_busy      = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule
`default_nettype wire

### src/matrix_multiply_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Load requests write one element of A or B; a compute request streams out
// every element of A * B in row-major order.
// For each element of a compute request, the shared MAC takes inner_len
// products, its pipeline drains, and the element is then handed to the
// output register. Input is stalled until the last element has been
// handed off. Reset sets all dimensions to 8; the element stores are not
// cleared and hold unknown data until written.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
    parameter int MAX_DIM   = mme_pkg::DEF_MAX_DIM,
    parameter int ELEM_BITS = mme_pkg::DEF_ELEM_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire mme_pkg::t_in_req              i_in_req,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output mme_pkg::t_out_req                  o_out_req,
    input  wire logic                          i_out_stall,
    input  wire logic                          i_cfg_we,
    input  wire logic [mme_pkg::CFG_IW-1:0]    i_cfg_index,
    input  wire logic [mme_pkg::CFG_W-1:0]     i_cfg_data
);
    import mme_pkg::*;

    localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_W-1:0]            r_a_rows;
    logic [CFG_W-1:0]            r_inner_len;
    logic [CFG_W-1:0]            r_b_cols;
    logic                        w_accept;
    logic                        w_in_range;
    logic                        w_we_a;
    logic                        w_we_b;
    logic [ADDR_W-1:0]           w_waddr;
    logic signed [ELEM_BITS-1:0] w_elem;
    logic                        w_busy;
    logic [ADDR_W-1:0]           w_a_addr;
    logic [ADDR_W-1:0]           w_b_addr;
    logic signed [ELEM_BITS-1:0] w_a_data;
    logic signed [ELEM_BITS-1:0] w_b_data;
    t_mac_ctl                    w_ctl;
    logic                        w_mac_done;
    logic signed [RES_W-1:0]     w_acc;

    function automatic logic [DIM_W-1:0] f_last_idx(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (v > CFG_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM - 1);
        end else begin
            return DIM_W'(v - 1'b1);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows    <= CFG_DIM_RESET;
            r_inner_len <= CFG_DIM_RESET;
            r_b_cols    <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_A_ROWS:    r_a_rows    <= i_cfg_data;
                CFG_INNER_LEN: r_inner_len <= i_cfg_data;
                CFG_B_COLS:    r_b_cols    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    generate
        if (ELEM_BITS <= VAL_W) begin : g_elem_trunc
            assign w_elem = i_in_req.elem_value[ELEM_BITS-1:0];
        end else begin : g_elem_sext
            assign w_elem = {{(ELEM_BITS-VAL_W){i_in_req.elem_value[VAL_W-1]}},
                             i_in_req.elem_value};
        end
    endgenerate

    assign w_accept   = i_in_valid && !w_busy;
    assign w_in_range = ({1'b0, i_in_req.elem_row} < (IDX_W+1)'(MAX_DIM)) &&
                        ({1'b0, i_in_req.elem_col} < (IDX_W+1)'(MAX_DIM));
    assign w_waddr    = ADDR_W'(i_in_req.elem_row) * ADDR_W'(MAX_DIM) +
                        ADDR_W'(i_in_req.elem_col);
    assign w_we_a     = w_accept && w_in_range && (i_in_req.opcode == OP_LOAD_A);
    assign w_we_b     = w_accept && w_in_range && (i_in_req.opcode == OP_LOAD_B);

    mme_ram #(
        .WIDTH  (ELEM_BITS),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_left_store (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (w_elem),
        .i_raddr (w_a_addr),
        .o_rdata (w_a_data)
    );

    mme_ram #(
        .WIDTH  (ELEM_BITS),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_right_store (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (w_elem),
        .i_raddr (w_b_addr),
        .o_rdata (w_b_data)
    );

    mme_mac #(
        .ELEM_BITS (ELEM_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_a_data),
        .i_b     (w_b_data),
        .o_done  (w_mac_done),
        .o_acc   (w_acc)
    );

    mme_seq #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept && (i_in_req.opcode == OP_COMPUTE)),
        .i_row_last  (f_last_idx(r_a_rows)),
        .i_col_last  (f_last_idx(r_b_cols)),
        .i_k_last    (f_last_idx(r_inner_len)),
        .o_busy      (w_busy),
        .o_a_addr    (w_a_addr),
        .o_b_addr    (w_b_addr),
        .o_ctl       (w_ctl),
        .i_mac_done  (w_mac_done),
        .i_acc       (w_acc),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall)
    );

    assign o_in_stall = w_busy;

endmodule
`default_nettype wire

### sim/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for matrix_multiply_engine. A directed table covers the
// element extremes, every opcode, the ignored opcode and dimension clamping.
// Random phases follow, each with its own dimensions; only elements that
// were loaded are ever read. Every product element is checked in order
// against an independent model of the stores and the dot products.
// ----------------------------------------------------------------------------
module tb;
    import mme_pkg::*;

    localparam int MAX_DIM    = DEF_MAX_DIM;
    localparam int SETTLE_CYC = 16;
    localparam int HOLD_CYC   = 300;
    localparam int DRAIN_CYC  = 50;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                    is_cfg;
        logic [CFG_IW-1:0]       cfg_idx;
        logic [CFG_W-1:0]        cfg_val;
        t_in_req                 req;
        logic                    has_exp;
        logic signed [RES_W-1:0] exp_value;
    } t_step;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_in_req           i_in_req    = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_out_req          o_out_req;
    logic              i_out_stall = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data  = '0;

    logic signed [VAL_W-1:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [VAL_W-1:0] b_mem [MAX_DIM*MAX_DIM];
    bit                      a_set [MAX_DIM*MAX_DIM];
    bit                      b_set [MAX_DIM*MAX_DIM];
    logic [CFG_W-1:0]        dim_rows  = CFG_DIM_RESET;
    logic [CFG_W-1:0]        dim_inner = CFG_DIM_RESET;
    logic [CFG_W-1:0]        dim_cols  = CFG_DIM_RESET;

    t_out_req product_q [$];
    t_step    dir_tab [$];
    t_out_req want;
    int       mismatch_cnt  = 0;
    int       burst_left    = 0;
    bit       hold_off_req  = 1'b0;
    bit       hold_done     = 1'b0;

    matrix_multiply_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #30000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int eff_dim(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic t_in_req mk_req(logic [1:0] op, int row, int col, int val);
        t_in_req r;
        r.opcode     = op;
        r.elem_row   = row[IDX_W-1:0];
        r.elem_col   = col[IDX_W-1:0];
        r.elem_value = val[VAL_W-1:0];
        return r;
    endfunction

    function automatic t_step cfg_row(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
        t_step s;
        s           = '0;
        s.is_cfg    = 1'b1;
        s.cfg_idx   = idx;
        s.cfg_val   = val;
        return s;
    endfunction

    function automatic t_step req_row(logic [1:0] op, int row, int col, int val,
                                      bit has_exp = 1'b0, longint e = 0);
        t_step s;
        s           = '0;
        s.req       = mk_req(op, row, col, val);
        s.has_exp   = has_exp;
        s.exp_value = e[RES_W-1:0];
        return s;
    endfunction

    function automatic int rand_value();
        case ($urandom_range(0, 7))
            0: return 32767;
            1: return -32768;
            2: return 0;
            default: return int'($urandom);
        endcase
    endfunction

    task automatic predict_products(t_in_req r);
        int       idx;
        int       nr;
        int       nk;
        int       nc;
        longint   acc;
        t_out_req res;
        idx = int'(r.elem_row) * MAX_DIM + int'(r.elem_col);
        case (r.opcode)
            OP_LOAD_A: begin
                a_mem[idx] = r.elem_value;
                a_set[idx] = 1'b1;
            end
            OP_LOAD_B: begin
                b_mem[idx] = r.elem_value;
                b_set[idx] = 1'b1;
            end
            OP_COMPUTE: begin
                nr = eff_dim(dim_rows);
                nk = eff_dim(dim_inner);
                nc = eff_dim(dim_cols);
                for (int rr = 0; rr < nr; rr++) begin
                    for (int cc = 0; cc < nc; cc++) begin
                        acc = 0;
                        for (int k = 0; k < nk; k++) begin
                            acc += longint'(a_mem[rr*MAX_DIM+k]) *
                                   longint'(b_mem[k*MAX_DIM+cc]);
                        end
                        res.res_row   = rr[IDX_W-1:0];
                        res.res_col   = cc[IDX_W-1:0];
                        res.res_value = acc[RES_W-1:0];
                        res.last      = (rr == nr - 1) && (cc == nc - 1);
                        product_q.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // bursts of random length separated by random gaps
    task automatic issue_req(t_in_req r, bit predict);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
            gap = $urandom_range(0, 6);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_req   = r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        if (predict) predict_products(r);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (product_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_dim(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        case (idx)
            CFG_A_ROWS:    dim_rows  = val;
            CFG_INNER_LEN: dim_inner = val;
            CFG_B_COLS:    dim_cols  = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_phase(int n_items, logic [CFG_W-1:0] nr_cfg,
                             logic [CFG_W-1:0] nk_cfg, logic [CFG_W-1:0] nc_cfg,
                             bit with_hold);
        int         sent;
        int         nr;
        int         nk;
        int         nc;
        logic [1:0] op;
        settle();
        set_dim(CFG_A_ROWS, nr_cfg);
        set_dim(CFG_INNER_LEN, nk_cfg);
        set_dim(CFG_B_COLS, nc_cfg);
        nr   = eff_dim(nr_cfg);
        nk   = eff_dim(nk_cfg);
        nc   = eff_dim(nc_cfg);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(0, 1))
                        issue_req(mk_req(OP_LOAD_A, $urandom_range(0, nr - 1),
                                         $urandom_range(0, nk - 1), rand_value()), 1'b1);
                    else
                        issue_req(mk_req(OP_LOAD_B, $urandom_range(0, nk - 1),
                                         $urandom_range(0, nc - 1), rand_value()), 1'b1);
                    sent++;
                end
                // load whatever the product still needs
                for (int rr = 0; rr < nr; rr++) begin
                    for (int k = 0; k < nk; k++) begin
                        if (!a_set[rr*MAX_DIM+k]) begin
                            issue_req(mk_req(OP_LOAD_A, rr, k, rand_value()), 1'b1);
                            sent++;
                        end
                    end
                end
                for (int k = 0; k < nk; k++) begin
                    for (int cc = 0; cc < nc; cc++) begin
                        if (!b_set[k*MAX_DIM+cc]) begin
                            issue_req(mk_req(OP_LOAD_B, k, cc, rand_value()), 1'b1);
                            sent++;
                        end
                    end
                end
                issue_req(mk_req(OP_COMPUTE, $urandom_range(0, 7),
                                 $urandom_range(0, 7), rand_value()), 1'b1);
                sent++;
                if (with_hold) hold_off_req = 1'b1;
            end else begin
                case ($urandom_range(0, 2))
                    0: op = OP_LOAD_A;
                    1: op = OP_LOAD_B;
                    default: op = OP_UNUSED;
                endcase
                issue_req(mk_req(op, $urandom_range(0, 7), $urandom_range(0, 7),
                                 rand_value()), 1'b1);
                if (op != OP_UNUSED) sent++;
            end
        end
    endtask

    // receiver stall pattern, plus one long hold-off on request
    initial begin
        int mode;
        int cnt;
        cnt = 0;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(64, 256)) begin
                @(negedge i_clk);
                if (hold_off_req && !hold_done) begin
                    hold_done   = 1'b1;
                    i_out_stall = 1'b1;
                    repeat (HOLD_CYC) @(negedge i_clk);
                end
                cnt++;
                case (mode)
                    0: i_out_stall = 1'b0;
                    1: i_out_stall = ($urandom_range(0, 2) == 0);
                    2: i_out_stall = ((cnt % 7) < 3);
                    default: i_out_stall = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (product_q.size() == 0) begin
                mismatch_cnt++;
                $display("%0t unexpected result: expected none actual row %0d col %0d value %0d",
                         $time, o_out_req.res_row, o_out_req.res_col, o_out_req.res_value);
            end else begin
                want = product_q.pop_front();
                if (o_out_req.res_row !== want.res_row) begin
                    mismatch_cnt++;
                    $display("%0t res_row: expected %0d actual %0d",
                             $time, want.res_row, o_out_req.res_row);
                end
                if (o_out_req.res_col !== want.res_col) begin
                    mismatch_cnt++;
                    $display("%0t res_col: expected %0d actual %0d",
                             $time, want.res_col, o_out_req.res_col);
                end
                if (o_out_req.res_value !== want.res_value) begin
                    mismatch_cnt++;
                    $display("%0t res_value: expected %0d actual %0d",
                             $time, want.res_value, o_out_req.res_value);
                end
                if (o_out_req.last !== want.last) begin
                    mismatch_cnt++;
                    $display("%0t last: expected %0d actual %0d",
                             $time, want.last, o_out_req.last);
                end
            end
        end
    end

    initial begin
        t_step    s;
        t_out_req typed;

        dir_tab.push_back(cfg_row(CFG_A_ROWS, 4'd1));
        dir_tab.push_back(cfg_row(CFG_INNER_LEN, 4'd1));
        dir_tab.push_back(cfg_row(CFG_B_COLS, 4'd1));
        dir_tab.push_back(req_row(OP_LOAD_A, 0, 0, 32767));
        dir_tab.push_back(req_row(OP_LOAD_B, 0, 0, 32767));
        dir_tab.push_back(req_row(OP_COMPUTE, 0, 0, 0, 1'b1, 64'sd1073676289));
        dir_tab.push_back(req_row(OP_LOAD_A, 0, 0, -32768));
        dir_tab.push_back(req_row(OP_LOAD_B, 0, 0, -32768));
        dir_tab.push_back(req_row(OP_COMPUTE, 7, 7, -1, 1'b1, 64'sd1073741824));
        dir_tab.push_back(req_row(OP_LOAD_B, 0, 0, 32767));
        dir_tab.push_back(req_row(OP_COMPUTE, 0, 0, 0, 1'b1, -64'sd1073709056));
        // unused opcode must leave both stores alone
        dir_tab.push_back(req_row(OP_UNUSED, 0, 0, 0));
        dir_tab.push_back(req_row(OP_COMPUTE, 0, 0, 0, 1'b1, -64'sd1073709056));
        dir_tab.push_back(req_row(OP_LOAD_A, 7, 7, -1));
        dir_tab.push_back(req_row(OP_LOAD_B, 7, 7, 0));
        // zero dimensions act as one
        dir_tab.push_back(cfg_row(CFG_A_ROWS, 4'd0));
        dir_tab.push_back(cfg_row(CFG_INNER_LEN, 4'd0));
        dir_tab.push_back(cfg_row(CFG_B_COLS, 4'd0));
        dir_tab.push_back(req_row(OP_LOAD_A, 0, 0, 4096));
        dir_tab.push_back(req_row(OP_LOAD_B, 0, 0, -4096));
        dir_tab.push_back(req_row(OP_COMPUTE, 0, 0, 0, 1'b1, -64'sd16777216));
        dir_tab.push_back(req_row(OP_LOAD_A, 0, 0, -21846));
        dir_tab.push_back(req_row(OP_LOAD_B, 0, 0, 21845));
        dir_tab.push_back(req_row(OP_COMPUTE, 0, 0, 0));
        dir_tab.push_back(cfg_row(CFG_A_ROWS, 4'd2));
        dir_tab.push_back(cfg_row(CFG_INNER_LEN, 4'd2));
        dir_tab.push_back(cfg_row(CFG_B_COLS, 4'd2));
        dir_tab.push_back(req_row(OP_LOAD_A, 0, 1, 12345));
        dir_tab.push_back(req_row(OP_LOAD_A, 1, 0, -7));
        dir_tab.push_back(req_row(OP_LOAD_A, 1, 1, 32767));
        dir_tab.push_back(req_row(OP_LOAD_B, 0, 1, -32768));
        dir_tab.push_back(req_row(OP_LOAD_B, 1, 0, 1));
        dir_tab.push_back(req_row(OP_LOAD_B, 1, 1, -20000));
        dir_tab.push_back(req_row(OP_COMPUTE, 0, 0, 0));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) begin
            s = dir_tab[i];
            if (s.is_cfg) begin
                settle();
                set_dim(s.cfg_idx, s.cfg_val);
            end else begin
                issue_req(s.req, !s.has_exp);
                if (s.has_exp) begin
                    typed.res_row   = '0;
                    typed.res_col   = '0;
                    typed.res_value = s.exp_value;
                    typed.last      = 1'b1;
                    product_q.push_back(typed);
                end
            end
        end

        run_phase(20, 4'd1, 4'd15, 4'd1, 1'b0);
        run_phase(24, 4'd15, 4'd1, 4'd1, 1'b1);
        run_phase(20, 4'd1, 4'd1, 4'd12, 1'b0);
        run_phase(24, 4'd0, 4'd3, 4'd0, 1'b0);
        repeat (7) begin
            run_phase(22, 4'($urandom_range(0, 5)), 4'($urandom_range(0, 5)),
                      4'($urandom_range(0, 5)), 1'b0);
        end
        run_phase(30, 4'd8, 4'd8, 4'd8, 1'b0);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (product_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
